>>> hw/rtl/xlb_pkg.sv
// ----------------------------------------------------------------------------
// xlb_pkg
// shared types and constants for the xor linear basis
// ----------------------------------------------------------------------------
package xlb_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned CNT_W     = (WORD_BITS > 2) ? $clog2(WORD_BITS) : 1;
  localparam int unsigned RANK_W    = $clog2(WORD_BITS + 1);
  localparam int unsigned IN_W      = 32;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned OUT_RANK_W = 6;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;

  // word travelling down the chain and the one-hot bit it has claimed
  typedef struct packed {
    word_t word;
    word_t mask;
  } tok_t;

  // broadcast update for every row
  typedef struct packed {
    logic  clr;
    logic  en;
    word_t mask;
    word_t row;
  } wr_t;

endpackage

>>> hw/rtl/xlb_cell.sv
// ----------------------------------------------------------------------------
// xlb_cell
// one basis row: reduces the passing word and takes broadcast row updates
// ----------------------------------------------------------------------------
module xlb_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  xlb_pkg::word_t pos_i,
  input  xlb_pkg::tok_t  tok_i,
  input  xlb_pkg::wr_t   wr_i,
  output xlb_pkg::tok_t  tok_o
);

  xlb_pkg::word_t row_q, row_d;
  xlb_pkg::tok_t  tok_q, tok_d;
  logic           hit;

  always_comb begin
    hit   = |(tok_i.word & pos_i);
    tok_d = tok_i;
    if (hit) begin
      if (row_q != '0) begin
        tok_d.word = tok_i.word ^ row_q;
      end else if (tok_i.mask == '0) begin
        tok_d.mask = pos_i;
      end
    end
  end

  always_comb begin
    row_d = row_q;
    if (wr_i.clr) begin
      row_d = '0;
    end else if (wr_i.en) begin
      if (pos_i == wr_i.mask) begin
        row_d = wr_i.row;
      end else if (|(row_q & wr_i.mask)) begin
        row_d = row_q ^ wr_i.row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_o = tok_q;

endmodule

>>> hw/rtl/xor_linear_basis.sv
// ----------------------------------------------------------------------------
// xor_linear_basis
// fully reduced xor linear basis over gf(2) with running maximum xor and rank
// ----------------------------------------------------------------------------
// An insert beat walks its word down a chain of WORD_BITS row cells, one cell
// per cycle, then writes the new row into the basis in ST_WRITE: busy_o stays
// high through the scan and the write, and the result strobe follows on the
// next cycle. A clear beat leaves busy_o low and its result strobes on the
// next cycle. valid_o is high for exactly one cycle per beat and cannot be
// held off, so the receiver must take every result as it appears; a new beat
// may be started in the cycle the previous result is shown.
// ----------------------------------------------------------------------------
module xor_linear_basis (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             cmd_i,
  input  logic [xlb_pkg::IN_W-1:0]         value_i,
  output logic                             valid_o,
  output logic [xlb_pkg::OUT_W-1:0]        max_xor_o,
  output logic                             independent_o,
  output logic [xlb_pkg::OUT_RANK_W-1:0]   rank_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_e;

  state_e                       state_q, state_d;
  logic [xlb_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  xlb_pkg::word_t               word_q;
  xlb_pkg::word_t               total_q, total_d;
  logic [xlb_pkg::RANK_W-1:0]   rank_q, rank_d;
  logic                         valid_q, valid_d;
  logic [xlb_pkg::OUT_W-1:0]    max_xor_q;
  logic                         indep_q;
  logic [xlb_pkg::OUT_RANK_W-1:0] rank_out_q;
  logic                         accept;
  logic                         claimed;
  xlb_pkg::tok_t                tok [xlb_pkg::WORD_BITS+1];
  xlb_pkg::wr_t                 wr;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign claimed = |tok[0].mask;

  assign tok[xlb_pkg::WORD_BITS].word = word_q;
  assign tok[xlb_pkg::WORD_BITS].mask = '0;

  for (genvar k = 0; k < xlb_pkg::WORD_BITS; k++) begin : g_cell
    xlb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .pos_i  (xlb_pkg::word_t'(1) << k),
      .tok_i  (tok[k+1]),
      .wr_i   (wr),
      .tok_o  (tok[k])
    );
  end

  always_comb begin
    wr.clr  = accept && (cmd_i == xlb_pkg::CMD_CLEAR);
    wr.en   = (state_q == ST_WRITE) && claimed;
    wr.mask = tok[0].mask;
    wr.row  = tok[0].word;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    rank_d  = rank_q;
    valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == xlb_pkg::CMD_CLEAR) begin
            total_d = '0;
            rank_d  = '0;
            valid_d = 1'b1;
          end else begin
            state_d = ST_SCAN;
            cnt_d   = '0;
          end
        end
      end
      ST_SCAN: begin
        if (cnt_q == xlb_pkg::CNT_W'(xlb_pkg::WORD_BITS - 1)) begin
          state_d = ST_WRITE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
        valid_d = 1'b1;
        if (claimed) begin
          // rows above that hold the new bit flip in pairs with the new row
          if ((total_q & tok[0].mask) == '0) begin
            total_d = total_q ^ tok[0].word;
          end
          rank_d = rank_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      total_q <= '0;
      rank_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      rank_q  <= rank_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= xlb_pkg::word_t'(value_i);
    end
    if (valid_d) begin
      max_xor_q  <= xlb_pkg::OUT_W'(total_d);
      indep_q    <= (state_q == ST_WRITE) && claimed;
      rank_out_q <= xlb_pkg::OUT_RANK_W'(rank_d);
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign valid_o       = valid_q;
  assign max_xor_o     = max_xor_q;
  assign independent_o = indep_q;
  assign rank_o        = rank_out_q;

`ifndef ASSERT_OFF
  a_valid_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q == ST_WRITE || (accept && cmd_i == xlb_pkg::CMD_CLEAR)))
    else $error("result strobe without a finished beat");

  a_rank_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rank_q <= xlb_pkg::RANK_W'(xlb_pkg::WORD_BITS))
    else $error("rank above word width");

  a_indep_rank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && indep_q) |-> (rank_q == $past(rank_q) + 1'b1))
    else $error("independent word did not raise rank");

  a_claim_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> $onehot0(tok[0].mask))
    else $error("more than one bit claimed");

  a_scan_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(accept && cmd_i == xlb_pkg::CMD_INSERT))
    else $error("busy without an insert beat");
`endif

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for xor_linear_basis: directed and random insert and
// clear beats, each result compared against a behavioural gf(2) basis
// ----------------------------------------------------------------------------

class basis_scoreboard;

  typedef struct packed {
    logic [xlb_pkg::OUT_W-1:0]      max_xor;
    logic                           independent;
    logic [xlb_pkg::OUT_RANK_W-1:0] rank;
  } basis_result_t;

  xlb_pkg::word_t rows [xlb_pkg::WORD_BITS];
  basis_result_t  expected_results [$];
  int unsigned    errors;

  function new();
    errors = 0;
    clear_rows();
  endfunction

  function void clear_rows();
    for (int i = 0; i < xlb_pkg::WORD_BITS; i++) rows[i] = '0;
  endfunction

  function bit insert_word(xlb_pkg::word_t w);
    for (int j = xlb_pkg::WORD_BITS - 1; j >= 0; j--) begin
      if (w[j]) begin
        if (rows[j] != '0) begin
          w ^= rows[j];
        end else begin
          for (int k = j - 1; k >= 0; k--) if (w[k]) w ^= rows[k];
          rows[j] = w;
          for (int k = j + 1; k < xlb_pkg::WORD_BITS; k++) if (rows[k][j]) rows[k] ^= w;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function void note_beat(logic cmd, logic [xlb_pkg::IN_W-1:0] value);
    basis_result_t  res;
    xlb_pkg::word_t acc;
    int unsigned    cnt;
    res = '0;
    acc = '0;
    cnt = 0;
    if (cmd == xlb_pkg::CMD_CLEAR) clear_rows();
    else res.independent = insert_word(xlb_pkg::word_t'(value));
    for (int i = 0; i < xlb_pkg::WORD_BITS; i++) begin
      acc ^= rows[i];
      if (rows[i] != '0) cnt++;
    end
    res.max_xor = acc[xlb_pkg::OUT_W-1:0];
    res.rank    = cnt[xlb_pkg::OUT_RANK_W-1:0];
    expected_results.insert(expected_results.size(), res);
  endfunction

  function void check_result(logic [xlb_pkg::OUT_W-1:0] max_xor, logic independent,
                             logic [xlb_pkg::OUT_RANK_W-1:0] rank);
    basis_result_t exp_res;
    if (expected_results.size() == 0) begin
      $error("unexpected result beat: max_xor %0h independent %0b rank %0d",
             max_xor, independent, rank);
      errors++;
      return;
    end
    exp_res = expected_results.pop_front();
    if (max_xor !== exp_res.max_xor) begin
      $error("max_xor mismatch: expected %0h actual %0h", exp_res.max_xor, max_xor);
      errors++;
    end
    if (independent !== exp_res.independent) begin
      $error("independent mismatch: expected %0b actual %0b", exp_res.independent, independent);
      errors++;
    end
    if (rank !== exp_res.rank) begin
      $error("rank mismatch: expected %0d actual %0d", exp_res.rank, rank);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_results.size();
  endfunction

endclass

module tb;

  localparam int unsigned RANDOM_BEATS = 2000;
  localparam int unsigned QUIET_BEATS  = 300;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic                           clk_i;
  logic                           rst_ni  = 1'b0;
  logic                           start_i = 1'b0;
  logic                           cmd_i   = xlb_pkg::CMD_INSERT;
  logic [xlb_pkg::IN_W-1:0]       value_i = '0;
  logic                           busy_o;
  logic                           valid_o;
  logic [xlb_pkg::OUT_W-1:0]      max_xor_o;
  logic                           independent_o;
  logic [xlb_pkg::OUT_RANK_W-1:0] rank_o;

  basis_scoreboard          basis_sb = new();
  logic [xlb_pkg::IN_W-1:0] words_since_clear [$];
  int unsigned              stall_cycles = 0;

  xor_linear_basis i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .valid_o       (valid_o),
    .max_xor_o     (max_xor_o),
    .independent_o (independent_o),
    .rank_o        (rank_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) basis_sb.check_result(max_xor_o, independent_o, rank_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || valid_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("xor_linear_basis regression: fail");
    $finish;
  end

  task automatic send_beat(input logic cmd, input logic [xlb_pkg::IN_W-1:0] value);
    start_i <= 1'b1;
    cmd_i   <= cmd;
    value_i <= value;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    basis_sb.note_beat(cmd, value);
    if (cmd == xlb_pkg::CMD_CLEAR) words_since_clear.delete();
    else words_since_clear.insert(words_since_clear.size(), value);
  endtask

  task automatic gap_burst();
    start_i <= 1'b0;
    if ($urandom_range(0, 1) == 1) begin
      @(posedge clk_i);
      while (busy_o) @(posedge clk_i);
    end
    repeat ($urandom_range(1, 3)) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (basis_sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [xlb_pkg::IN_W-1:0] dependent_word();
    logic [xlb_pkg::IN_W-1:0] w;
    w = '0;
    foreach (words_since_clear[i]) if ($urandom_range(0, 1) == 1) w ^= words_since_clear[i];
    return w;
  endfunction

  task automatic random_beat();
    int unsigned              pick;
    logic [xlb_pkg::IN_W-1:0] w;
    pick = $urandom_range(0, 999);
    if (pick < 15) begin
      send_beat(xlb_pkg::CMD_CLEAR, $urandom());
    end else begin
      if (pick < 35) w = '0;
      else if (pick < 200) w = (xlb_pkg::IN_W'(1) << $urandom_range(0, xlb_pkg::IN_W - 1)) |
                               (xlb_pkg::IN_W'($urandom_range(0, 1)) <<
                                $urandom_range(0, xlb_pkg::IN_W - 1));
      else if (pick < 400) w = dependent_word();
      else if (pick < 550) w = $urandom() & $urandom();
      else w = $urandom();
      send_beat(xlb_pkg::CMD_INSERT, w);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edge values, dependent words and clears with junk on value
    send_beat(xlb_pkg::CMD_CLEAR,  32'h0000_0000);
    send_beat(xlb_pkg::CMD_INSERT, 32'h0000_0000);
    send_beat(xlb_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    send_beat(xlb_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    send_beat(xlb_pkg::CMD_INSERT, 32'h0000_0001);
    send_beat(xlb_pkg::CMD_INSERT, 32'hFFFF_FFFE);
    send_beat(xlb_pkg::CMD_INSERT, 32'h8000_0000);
    send_beat(xlb_pkg::CMD_INSERT, 32'h5555_5555);
    gap_burst();
    send_beat(xlb_pkg::CMD_INSERT, 32'hAAAA_AAAA);
    send_beat(xlb_pkg::CMD_INSERT, 32'h7FFF_FFFE);
    send_beat(xlb_pkg::CMD_CLEAR,  32'hDEAD_BEEF);
    send_beat(xlb_pkg::CMD_INSERT, 32'h8000_0001);
    send_beat(xlb_pkg::CMD_INSERT, 32'h4000_0000);
    send_beat(xlb_pkg::CMD_INSERT, 32'hC000_0001);
    send_beat(xlb_pkg::CMD_INSERT, 32'h0000_0003);
    send_beat(xlb_pkg::CMD_INSERT, 32'h0000_0002);
    send_beat(xlb_pkg::CMD_CLEAR,  32'hFFFF_FFFF);
    send_beat(xlb_pkg::CMD_CLEAR,  32'h0000_0000);
    send_beat(xlb_pkg::CMD_INSERT, 32'h0001_0000);
    wait_drained();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      random_beat();
      if (n < RANDOM_BEATS - QUIET_BEATS) begin
        if (n % 500 == 250) wait_drained();
        else if ($urandom_range(0, 3) == 0) gap_burst();
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (basis_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (basis_sb.errors == 0 && basis_sb.pending() == 0) begin
      $display("xor_linear_basis regression: pass");
    end else begin
      $display("xor_linear_basis regression: fail");
    end
    $finish;
  end

endmodule
